@@ rtl/core/pfd_pkg.sv @@
// Shared constants, codes and types for the polyphase FIR decimator.
package pfd_pkg;

  localparam int MAX_PHASES_DEF = 16;
  localparam int MAX_TAPS_DEF   = 16;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COEF_BITS_DEF   = 18;

  localparam int CMD_W      = 2;
  localparam int COEF_IDX_W = 4;
  localparam int CFG_W      = 5;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;

  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_COEF   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_DECIM = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_TAPS  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } pfd_state_t;

endpackage

@@ rtl/core/polyphase_fir_decimator_unit.sv @@
// Polyphase FIR decimator: coefficient and delay memories with a single shared MAC.
//
//  channel | direction | handshake                 | payload
//  in_     | input     | in_valid / in_stall       | command, sample, coef_phase/tap/value
//  out_    | output    | out_valid / out_stall     | out_sample
//  cfg_    | input     | APB write, pready high    | decimation_factor, taps_per_phase
//
// A sample request writes the delay memory when it is accepted, then issues T reads
// (T = effective taps per phase) through the single MAC, then drains and finishes.
// Coefficient, clear and unused requests complete on acceptance and do not raise in_stall.
// Reset (rst_n low, synchronous) clears the delay valid bits, the sum and the commutator.
// in_stall is high while a sample is in work; its last cycle waits while an earlier
// result is held by out_stall.
module polyphase_fir_decimator_unit #(
  parameter int MAX_PHASES         = pfd_pkg::MAX_PHASES_DEF,
  parameter int MAX_TAPS_PER_PHASE = pfd_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_BITS        = pfd_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS          = pfd_pkg::COEF_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pfd_pkg::CMD_W-1:0]           in_command,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample,
  input  logic [pfd_pkg::COEF_IDX_W-1:0]      in_coef_phase,
  input  logic [pfd_pkg::COEF_IDX_W-1:0]      in_coef_tap,
  input  logic signed [COEF_BITS-1:0]         in_coef_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SAMPLE_BITS-1:0]       out_sample,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [pfd_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [pfd_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [pfd_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready
);
  import pfd_pkg::*;

  localparam int DEPTH = MAX_PHASES * MAX_TAPS_PER_PHASE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PH_W  = $clog2(MAX_PHASES);
  localparam int PCW   = $clog2(MAX_PHASES + 1);
  localparam int TW    = (MAX_TAPS_PER_PHASE > 1) ? $clog2(MAX_TAPS_PER_PHASE) : 1;
  localparam int TCW   = $clog2(MAX_TAPS_PER_PHASE + 1);
  localparam int PW    = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W = PW + AW;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2 ** (SAMPLE_BITS - 1) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  function automatic logic [PCW-1:0] eff_phases(input logic [CFG_W-1:0] v);
    if (v == '0) return PCW'(1);
    else if (int'(v) > MAX_PHASES) return PCW'(MAX_PHASES);
    else return PCW'(v);
  endfunction

  function automatic logic [TCW-1:0] eff_taps(input logic [CFG_W-1:0] v);
    if (v == '0) return TCW'(1);
    else if (int'(v) > MAX_TAPS_PER_PHASE) return TCW'(MAX_TAPS_PER_PHASE);
    else return TCW'(v);
  endfunction

  // configuration
  logic [CFG_W-1:0] decim_r, taps_r;
  logic             cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic [PCW-1:0]   m_eff;
  logic [TCW-1:0]   t_eff;

  // storage
  logic signed [COEF_BITS-1:0]   coef_mem [DEPTH];
  logic signed [SAMPLE_BITS-1:0] dly_mem  [DEPTH];
  logic [DEPTH-1:0]              dly_vld_r;
  logic [TW-1:0]                 head_r [MAX_PHASES];

  // control
  pfd_state_t       state_r, state_nxt;
  logic [PH_W-1:0]  comm_r;
  logic [PH_W-1:0]  cur_p_r;
  logic [TCW-1:0]   k_r;
  logic [TW-1:0]    ptr_r;
  logic             rd_v_r, mul_v_r;
  logic signed [SAMPLE_BITS-1:0] dly_q_r;
  logic             vld_q_r;
  logic signed [COEF_BITS-1:0]   coef_q_r;
  logic signed [PW-1:0]          mul_r;
  logic signed [ACC_W-1:0]       sum_r;
  logic             out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;

  logic             in_acc;
  logic [PH_W-1:0]  acc_p;
  logic [TW-1:0]    new_head;
  logic [AW-1:0]    wr_dly_addr, wr_coef_addr, base_addr, rd_dly_addr, rd_coef_addr;
  logic             coef_ok;
  logic             issue, last_issue, finish;
  logic signed [ACC_W-1:0]       shifted;
  logic signed [SAMPLE_BITS-1:0] sat_val;

  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_idx == REG_DECIM) ? CFG_DATA_W'(decim_r) : CFG_DATA_W'(taps_r);
  assign m_eff      = eff_phases(decim_r);
  assign t_eff      = eff_taps(taps_r);

  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  always_comb begin
    if (PCW'(comm_r) >= m_eff) acc_p = PH_W'(m_eff - PCW'(1));
    else acc_p = comm_r;
    if (head_r[acc_p] == '0) new_head = TW'(MAX_TAPS_PER_PHASE - 1);
    else new_head = head_r[acc_p] - TW'(1);
  end

  assign wr_dly_addr  = AW'(int'(acc_p) * MAX_TAPS_PER_PHASE + int'(new_head));
  assign coef_ok      = (int'(in_coef_phase) < MAX_PHASES) &&
                        (int'(in_coef_tap) < MAX_TAPS_PER_PHASE);
  assign wr_coef_addr = AW'(int'(in_coef_phase) * MAX_TAPS_PER_PHASE + int'(in_coef_tap));
  assign base_addr    = AW'(int'(cur_p_r) * MAX_TAPS_PER_PHASE);
  assign rd_dly_addr  = base_addr + AW'(ptr_r);
  assign rd_coef_addr = base_addr + AW'(k_r);

  assign issue      = (state_r == ST_RUN);
  assign last_issue = issue && (k_r == t_eff - TCW'(1));
  assign finish     = (state_r == ST_DRAIN) && !rd_v_r && !mul_v_r &&
                      (!out_valid_r || !out_stall);

  always_comb begin
    shifted = sum_r >>> (COEF_BITS - 1);
    if (shifted > SAT_HI) sat_val = SAT_HI[SAMPLE_BITS-1:0];
    else if (shifted < SAT_LO) sat_val = SAT_LO[SAMPLE_BITS-1:0];
    else sat_val = shifted[SAMPLE_BITS-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_command == CMD_SAMPLE) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (last_issue) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (finish) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (in_acc && in_command == CMD_COEF && coef_ok) coef_mem[wr_coef_addr] <= in_coef_value;
    coef_q_r <= coef_mem[rd_coef_addr];
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_command == CMD_SAMPLE) dly_mem[wr_dly_addr] <= in_sample;
    dly_q_r <= dly_mem[rd_dly_addr];
    vld_q_r <= dly_vld_r[rd_dly_addr];
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc && in_command == CMD_SAMPLE) begin
      cur_p_r <= acc_p;
      ptr_r   <= new_head;
      k_r     <= '0;
    end else if (issue) begin
      k_r <= k_r + TCW'(1);
      if (ptr_r == TW'(MAX_TAPS_PER_PHASE - 1)) ptr_r <= '0;
      else ptr_r <= ptr_r + TW'(1);
    end
    if (rd_v_r) mul_r <= (vld_q_r ? dly_q_r : SAMPLE_BITS'(0)) * coef_q_r;
    if (finish) out_sample_r <= sat_val;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      decim_r     <= CFG_W'(1);
      taps_r      <= CFG_W'(1);
      comm_r      <= '0;
      sum_r       <= '0;
      dly_vld_r   <= '0;
      rd_v_r      <= 1'b0;
      mul_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_PHASES; i++) head_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= issue;
      mul_v_r <= rd_v_r;
      if (finish && cur_p_r == '0) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (mul_v_r) sum_r <= sum_r + ACC_W'(mul_r);

      if (in_acc) begin
        case (in_command)
          CMD_SAMPLE: begin
            dly_vld_r[wr_dly_addr] <= 1'b1;
            head_r[acc_p] <= new_head;
          end
          CMD_CLEAR: begin
            dly_vld_r <= '0;
            sum_r     <= '0;
            comm_r    <= PH_W'(m_eff - PCW'(1));
          end
          default: ;
        endcase
      end

      if (finish) begin
        if (cur_p_r == '0) begin
          sum_r       <= '0;
          comm_r      <= PH_W'(m_eff - PCW'(1));
        end else begin
          comm_r <= cur_p_r - PH_W'(1);
        end
      end

      if (cfg_wr) begin
        case (cfg_idx)
          REG_DECIM: begin
            decim_r <= cfg_pwdata[CFG_W-1:0];
            sum_r   <= '0;
            comm_r  <= PH_W'(eff_phases(cfg_pwdata[CFG_W-1:0]) - PCW'(1));
          end
          REG_TAPS: taps_r <= cfg_pwdata[CFG_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

@@ verif/tb_polyphase_fir_decimator_unit.sv @@
// Self-checking testbench for the polyphase FIR decimator unit.
module tb_polyphase_fir_decimator_unit;
  import pfd_pkg::*;

  localparam int SW = SAMPLE_BITS_DEF;
  localparam int CW = COEF_BITS_DEF;
  localparam int NPH = MAX_PHASES_DEF;
  localparam int NTP = MAX_TAPS_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = NTP + 12;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_REPORTS = 40;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [CMD_W-1:0] in_command;
  logic signed [SW-1:0] in_sample;
  logic [COEF_IDX_W-1:0] in_coef_phase;
  logic [COEF_IDX_W-1:0] in_coef_tap;
  logic signed [CW-1:0] in_coef_value;
  logic out_valid;
  logic out_stall;
  logic signed [SW-1:0] out_sample;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  // decimator state mirror
  logic signed [CW-1:0] coef_mirror [NPH][NTP];
  logic signed [SW-1:0] delay_mirror [NPH][NTP];
  longint branch_sum;
  int commutator_pos;
  logic [CFG_W-1:0] decim_reg;
  logic [CFG_W-1:0] taps_reg;

  logic signed [SW-1:0] expected_outputs [$];
  int err_count = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit gaps_off = 1'b0;

  polyphase_fir_decimator_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_sample(in_sample), .in_coef_phase(in_coef_phase), .in_coef_tap(in_coef_tap),
    .in_coef_value(in_coef_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_sample(out_sample),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int active_phases();
    if (decim_reg == 0) return 1;
    if (decim_reg > NPH) return NPH;
    return decim_reg;
  endfunction

  function automatic int active_taps();
    if (taps_reg == 0) return 1;
    if (taps_reg > NTP) return NTP;
    return taps_reg;
  endfunction

  function automatic void clear_branches();
    foreach (delay_mirror[p, k]) delay_mirror[p][k] = '0;
    branch_sum = 0;
    commutator_pos = active_phases() - 1;
  endfunction

  function automatic void predict_sample(input logic signed [SW-1:0] smp);
    int m;
    int t;
    int p;
    longint acc;
    longint y;
    m = active_phases();
    t = active_taps();
    p = commutator_pos;
    if (p >= m) p = m - 1;
    for (int k = NTP - 1; k > 0; k--) delay_mirror[p][k] = delay_mirror[p][k-1];
    delay_mirror[p][0] = smp;
    acc = 0;
    for (int k = 0; k < t; k++)
      acc += longint'(delay_mirror[p][k]) * longint'(coef_mirror[p][k]);
    branch_sum += acc;
    if (p == 0) begin
      y = branch_sum >>> (CW - 1);
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      expected_outputs.push_back(SW'(y));
      branch_sum = 0;
      commutator_pos = m - 1;
    end else begin
      commutator_pos = p - 1;
    end
  endfunction

  function automatic void apply_request(input logic [CMD_W-1:0] cmd,
                                        input logic signed [SW-1:0] smp,
                                        input logic [COEF_IDX_W-1:0] ph,
                                        input logic [COEF_IDX_W-1:0] tp,
                                        input logic signed [CW-1:0] cv);
    case (cmd)
      CMD_SAMPLE: begin
        predict_sample(smp);
      end
      CMD_COEF: begin
        coef_mirror[ph][tp] = cv;
      end
      CMD_CLEAR: begin
        clear_branches();
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic signed [SW-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'sh7fff;
    if (r == 1) return 16'sh8000;
    if (r == 2) return '0;
    return SW'($urandom);
  endfunction

  function automatic logic signed [CW-1:0] rand_coef();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 18'sh1ffff;
    if (r == 1) return 18'sh20000;
    return CW'($urandom);
  endfunction

  // output side: random stall pattern, result check
  always @(posedge clk) begin
    if (!rst_n || gaps_off) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 1) == 1) begin
      out_stall <= 1'b1;
      stall_left <= pick_gap();
    end else begin
      out_stall <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end
  end

  always @(posedge clk) begin
    logic signed [SW-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_outputs.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("%0t: unexpected out_sample, expected none, got %0d", $time, out_sample);
      end else begin
        want = expected_outputs.pop_front();
        if (out_sample !== want) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: out_sample mismatch, expected %0d, got %0d",
                     $time, want, out_sample);
        end
      end
    end
  end

  task automatic send_request(input logic [CMD_W-1:0] cmd,
                              input logic signed [SW-1:0] smp,
                              input logic [COEF_IDX_W-1:0] ph,
                              input logic [COEF_IDX_W-1:0] tp,
                              input logic signed [CW-1:0] cv);
    int gap;
    gap = gaps_off ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_sample <= smp;
    in_coef_phase <= ph;
    in_coef_tap <= tp;
    in_coef_value <= cv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_request(cmd, smp, ph, tp, cv);
  endtask

  task automatic send_sample(input logic signed [SW-1:0] smp);
    send_request(CMD_SAMPLE, smp, COEF_IDX_W'($urandom), COEF_IDX_W'($urandom),
                 CW'($urandom));
  endtask

  task automatic send_coef(input int ph, input int tp, input logic signed [CW-1:0] cv);
    send_request(CMD_COEF, SW'($urandom), COEF_IDX_W'(ph), COEF_IDX_W'(tp), cv);
  endtask

  task automatic send_command(input logic [CMD_W-1:0] cmd);
    send_request(cmd, SW'($urandom), COEF_IDX_W'($urandom), COEF_IDX_W'($urandom),
                 CW'($urandom));
  endtask

  // block is idle once all results are in and the last request has drained
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == REG_DECIM) begin
      decim_reg = value;
      branch_sum = 0;
      commutator_pos = active_phases() - 1;
    end else if (idx == REG_TAPS) begin
      taps_reg = value;
    end
    @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_W-1:0] m, input logic [CFG_W-1:0] t);
    settle();
    write_reg(REG_DECIM, m);
    write_reg(REG_TAPS, t);
  endtask

  task automatic test_reset_defaults();
    send_coef(0, 0, 18'sh1ffff);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample('0);
  endtask

  task automatic test_coef_bank();
    for (int p = 0; p < NPH; p++)
      for (int t = 0; t < NTP; t++)
        send_coef(p, t, rand_coef());
  endtask

  task automatic test_saturation();
    configure(5'd2, 5'd2);
    for (int p = 0; p < 2; p++)
      for (int t = 0; t < 2; t++)
        send_coef(p, t, 18'sh1ffff);
    repeat (4) send_sample(16'sh7fff);
    repeat (4) send_sample(16'sh8000);
  endtask

  task automatic test_clear_and_unused();
    send_sample(16'sd1000);
    send_command(CMD_CLEAR);
    send_sample(16'sh7fff);
    send_command(CMD_UNUSED);
    send_sample(-16'sd1234);
    send_coef(5, 3, 18'sh20000);
    send_sample(16'sd77);
    send_sample(16'sh8000);
  endtask

  task automatic test_register_extremes();
    logic [CFG_W-1:0] m_set [6] = '{5'd0, 5'd31, 5'd16, 5'd17, 5'd1, 5'd16};
    logic [CFG_W-1:0] t_set [6] = '{5'd0, 5'd31, 5'd16, 5'd1, 5'd17, 5'd1};
    for (int i = 0; i < 6; i++) begin
      configure(m_set[i], t_set[i]);
      repeat (active_phases() + 2) send_sample(rand_sample());
    end
    // change taps alone with a cycle in progress
    settle();
    write_reg(REG_TAPS, 5'd3);
    repeat (active_phases() + 1) send_sample(rand_sample());
  endtask

  task automatic test_random_traffic();
    int r;
    logic [CFG_W-1:0] m;
    logic [CFG_W-1:0] t;
    for (int ph = 0; ph < 10; ph++) begin
      settle();
      m = ($urandom_range(0, 4) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(1, 8));
      t = ($urandom_range(0, 4) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(1, 16));
      if ($urandom_range(0, 3) != 0) write_reg(REG_DECIM, m);
      write_reg(REG_TAPS, t);
      gaps_off = (ph % 4 == 3);
      repeat (48) begin
        r = $urandom_range(0, 99);
        if (r < 82) send_sample(rand_sample());
        else if (r < 92) send_coef($urandom_range(0, NPH - 1), $urandom_range(0, NTP - 1),
                                   rand_coef());
        else if (r < 96) send_command(CMD_CLEAR);
        else send_command(CMD_UNUSED);
      end
    end
    gaps_off = 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_command <= CMD_SAMPLE;
    in_sample <= '0;
    in_coef_phase <= '0;
    in_coef_tap <= '0;
    in_coef_value <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    foreach (coef_mirror[p, k]) coef_mirror[p][k] = '0;
    decim_reg = 5'd1;
    taps_reg = 5'd1;
    clear_branches();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_coef_bank();
    test_saturation();
    test_clear_and_unused();
    test_register_extremes();
    test_random_traffic();

    settle();
    repeat (40) @(posedge clk);
    if (err_count == 0 && expected_outputs.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

@@ polyphase_fir_decimator_unit.f @@
rtl/core/pfd_pkg.sv
rtl/core/polyphase_fir_decimator_unit.sv
verif/tb_polyphase_fir_decimator_unit.sv
